@@ rtl/core/q2e_pkg.sv @@
// Shared types, constants and the arctangent table for the quaternion to Euler block.
`default_nettype none
package q2e_pkg;

  localparam int AngW   = 34;
  localparam int CordW  = 44;
  localparam int TabLen = 24;
  localparam logic signed [AngW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [AngW-1:0] HalfPiQ30 = 34'sd1686629713;

  typedef logic signed [AngW-1:0] ang_t;
  typedef logic signed [CordW-1:0] cord_t;

  typedef struct packed {
    cord_t x;
    cord_t y;
    ang_t  z;
    logic  zero;
  } vec_t;

  typedef struct packed {
    logic       clamped;
    logic       neg;
  } pitch_tag_t;

  function automatic ang_t atan_q30(input int i);
    ang_t r;
    case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: r = (i < TabLen) ? ang_t'(34'sd1 << (30 - i)) : '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/q2e_if.sv @@
// Valid/ready stream interfaces for quaternion input and Euler angle output.
`default_nettype none
interface q2e_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic pitch_clamped;
  modport source(output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                 input ready);
  modport sink(input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
               output ready);
endinterface
`default_nettype wire

@@ rtl/core/quaternion_to_euler.sv @@
// Quaternion to ZYX Euler angle converter, pipelined CORDIC datapath.
// Usage:
//   Channel in  (q2e_in_if sink): quat_w/x/y/z, signed Q1.14.
//   Channel out (q2e_out_if source): roll, yaw in Q2.13 and pitch in Q1.13 radians,
//   and pitch_clamped, set when |2(wy - zx)| >= 1 and pitch is forced to +-pi/2.
//   Throughput is one quaternion per cycle while the receiver does not stall. The
//   pipeline holds one product stage, one sum stage, 31 square root stages, one
//   normalizing stage, CORDIC_STEPS cells (at most TabLen) and the output
//   register, which rounds.
//   Roll and yaw operands travel in delay lines alongside the square root.
//   The whole pipeline advances only when the output register is empty or
//   being taken, so a stalled receiver holds every stage and in.ready drops.
//   Reset clears the valid marks of all stages; data registers are not reset.
`default_nettype none
module quaternion_to_euler #(
  parameter int CORDIC_STEPS = 16,
  parameter int QUAT_FRAC_BITS = 14,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input wire logic clk,
  input wire logic rst,
  q2e_in_if.sink   in_ch,
  q2e_out_if.source out_ch
);
  localparam int NC = (CORDIC_STEPS < q2e_pkg::TabLen) ? CORDIC_STEPS : q2e_pkg::TabLen;
  localparam int SQ = 31;
  localparam int LAT = 2 + SQ + 1 + NC + 1;
  localparam int SH = 2 * QUAT_FRAC_BITS - 30;
  localparam int RS = 30 - ANGLE_FRAC_BITS;

  logic en;
  logic [LAT-1:0] vld;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: products.
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= in_ch.quat_w * in_ch.quat_x;
      p_yz <= in_ch.quat_y * in_ch.quat_z;
      p_xx <= in_ch.quat_x * in_ch.quat_x;
      p_yy <= in_ch.quat_y * in_ch.quat_y;
      p_wy <= in_ch.quat_w * in_ch.quat_y;
      p_zx <= in_ch.quat_z * in_ch.quat_x;
      p_wz <= in_ch.quat_w * in_ch.quat_z;
      p_xy <= in_ch.quat_x * in_ch.quat_y;
      p_zz <= in_ch.quat_z * in_ch.quat_z;
    end
  end

  // Stage 2: sums and pitch operand.
  localparam logic signed [63:0] One = 64'sd1 <<< (2 * QUAT_FRAC_BITS);
  localparam logic [61:0] One60 = 62'd1 << 60;
  logic signed [63:0] sr, cr, sp, sy, cy, s30c;
  logic signed [63:0] sr_q, cr_q, sy_q, cy_q, s30_q;
  logic [61:0] prod_q;
  q2e_pkg::pitch_tag_t tag_c, tag_q;
  logic signed [30:0] s30n;
  logic signed [61:0] sq;
  logic [61:0] pr;
  always_comb begin
    sr = 64'sd2 * (64'(p_wx) + 64'(p_yz));
    cr = One - 64'sd2 * (64'(p_xx) + 64'(p_yy));
    sp = 64'sd2 * (64'(p_wy) - 64'(p_zx));
    sy = 64'sd2 * (64'(p_wz) + 64'(p_xy));
    cy = One - 64'sd2 * (64'(p_yy) + 64'(p_zz));
    s30c = (SH >= 0) ? (sp >>> ((SH >= 0) ? SH : 0)) : (sp <<< ((SH < 0) ? -SH : 0));
    tag_c.clamped = (sp >= One) || (sp <= -One);
    tag_c.neg = !(sp > 0);
    // Outside the clamp |s30| < 2^30, so (1 - s)(1 + s) is formed as 2^60 - s^2.
    s30n = s30c[30:0];
    sq = s30n * s30n;
    pr = One60 - $unsigned(sq);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sr_q <= sr; cr_q <= cr; sy_q <= sy; cy_q <= cy;
      s30_q <= s30c; tag_q <= tag_c;
      prod_q <= tag_c.clamped ? '0 : pr;
    end
  end

  // Square root runs while roll/yaw operands and s30 wait in delay lines.
  logic [30:0] c30;
  q2e_isqrt u_sqrt (.clk(clk), .en(en), .n(prod_q), .root(c30));

  logic signed [63:0] dsr [1:SQ], dcr [1:SQ], dsy [1:SQ], dcy [1:SQ], ds [1:SQ];
  q2e_pkg::pitch_tag_t dt [1:SQ+NC+1];
  always_ff @(posedge clk) begin
    if (en) begin
      dsr[1] <= sr_q; dcr[1] <= cr_q;
      dsy[1] <= sy_q; dcy[1] <= cy_q; ds[1] <= s30_q;
      dt[1] <= tag_q;
      for (int k = 1; k < SQ; k++) begin
        dsr[k+1] <= dsr[k]; dcr[k+1] <= dcr[k];
        dsy[k+1] <= dsy[k]; dcy[k+1] <= dcy[k]; ds[k+1] <= ds[k];
      end
      for (int k = 1; k < SQ + NC + 1; k++) dt[k+1] <= dt[k];
    end
  end

  q2e_pkg::ang_t a_r, a_p, a_y;
  q2e_chain #(.STEPS(CORDIC_STEPS)) u_roll (.clk(clk), .en(en),
    .ys(dsr[SQ]), .xs(dcr[SQ]), .ang(a_r));
  q2e_chain #(.STEPS(CORDIC_STEPS)) u_pitch (.clk(clk), .en(en),
    .ys(ds[SQ]), .xs({33'd0, c30}), .ang(a_p));
  q2e_chain #(.STEPS(CORDIC_STEPS)) u_yaw (.clk(clk), .en(en),
    .ys(dsy[SQ]), .xs(dcy[SQ]), .ang(a_y));

  function automatic logic signed [q2e_pkg::AngW-1:0] rnd(
    input q2e_pkg::ang_t z, input q2e_pkg::ang_t lim);
    logic signed [q2e_pkg::AngW:0] v, l;
    v = ($signed({z[q2e_pkg::AngW-1], z}) + (35'sd1 <<< (RS - 1))) >>> RS;
    l = ($signed({lim[q2e_pkg::AngW-1], lim}) + (35'sd1 <<< (RS - 1))) >>> RS;
    if (v > l) v = l;
    if (v < -l) v = -l;
    return q2e_pkg::AngW'(v);
  endfunction

  q2e_pkg::pitch_tag_t tg;
  logic signed [q2e_pkg::AngW-1:0] ro, po, yo;
  always_comb begin
    tg = dt[SQ + NC + 1];
    ro = rnd(a_r, q2e_pkg::PiQ30);
    yo = rnd(a_y, q2e_pkg::PiQ30);
    if (tg.clamped)
      po = rnd(tg.neg ? -q2e_pkg::HalfPiQ30 : q2e_pkg::HalfPiQ30, q2e_pkg::HalfPiQ30);
    else
      po = rnd(a_p, q2e_pkg::HalfPiQ30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.roll_angle <= ro[15:0];
      out_ch.pitch_angle <= po[14:0];
      out_ch.yaw_angle <= yo[15:0];
      out_ch.pitch_clamped <= tg.clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_ch.valid};
    end
  end
  assign out_ch.valid = vld[LAT-1];
endmodule
`default_nettype wire

@@ rtl/core/q2e_cell.sv @@
// One vectoring CORDIC micro-rotation cell with its pipeline register.
`default_nettype none
module q2e_cell #(
  parameter int STEP = 0
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  q2e_pkg::vec_t     din,
  output q2e_pkg::vec_t     dout
);
  q2e_pkg::vec_t nxt;
  q2e_pkg::cord_t dx, dy;

  always_comb begin
    dx = din.y >>> STEP;
    dy = din.x >>> STEP;
    nxt = din;
    if (!din.y[q2e_pkg::CordW-1]) begin
      nxt.x = din.x + dx;
      nxt.y = din.y - dy;
      nxt.z = din.z + q2e_pkg::atan_q30(STEP);
    end else begin
      nxt.x = din.x - dx;
      nxt.y = din.y + dy;
      nxt.z = din.z - q2e_pkg::atan_q30(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/q2e_chain.sv @@
// Normalizing front stage and row of CORDIC cells computing atan2 in Q30.
`default_nettype none
module q2e_chain #(
  parameter int STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [63:0] ys,
  input  wire logic signed [63:0] xs,
  output q2e_pkg::ang_t           ang
);
  localparam int NCELL = (STEPS < q2e_pkg::TabLen) ? STEPS : q2e_pkg::TabLen;

  logic [63:0] ax, ay, m;
  logic [6:0]  lz;
  logic signed [63:0] xn, yn;
  q2e_pkg::vec_t v0;
  q2e_pkg::vec_t chain [NCELL+1];

  // The larger magnitude is placed in [2^39, 2^40) by one barrel shift.
  always_comb begin
    ax = xs[63] ? 64'(-xs) : xs;
    ay = ys[63] ? 64'(-ys) : ys;
    m  = (ax > ay) ? ax : ay;
    lz = 7'd64;
    for (int b = 0; b < 64; b++) begin
      if (m[b]) lz = 7'(63 - b);
    end
    if (lz < 7'd24) begin
      xn = xs >>> (7'd24 - lz);
      yn = ys >>> (7'd24 - lz);
    end else begin
      xn = xs <<< (lz - 7'd24);
      yn = ys <<< (lz - 7'd24);
    end
    v0.zero = (m == '0);
    v0.z = '0;
    v0.x = q2e_pkg::CordW'(xn);
    v0.y = q2e_pkg::CordW'(yn);
    if (xn[63]) begin
      if (!yn[63]) begin
        v0.x = q2e_pkg::CordW'(yn);
        v0.y = q2e_pkg::CordW'(-xn);
        v0.z = q2e_pkg::HalfPiQ30;
      end else begin
        v0.x = q2e_pkg::CordW'(-yn);
        v0.y = q2e_pkg::CordW'(xn);
        v0.z = -q2e_pkg::HalfPiQ30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0] <= v0;
    end
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    q2e_cell #(.STEP(i)) u_cell (
      .clk(clk), .en(en), .din(chain[i]), .dout(chain[i+1])
    );
  end

  assign ang = chain[NCELL].zero ? '0 : chain[NCELL].z;
endmodule
`default_nettype wire

@@ rtl/core/q2e_isqrt.sv @@
// Pipelined restoring integer square root, one result bit per stage.
`default_nettype none
module q2e_isqrt (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [61:0] n,
  output logic      [30:0] root
);
  localparam int NB = 31;
  logic [63:0] rem [NB+1];
  logic [31:0] res [NB+1];

  assign rem[0] = {2'b00, n};
  assign res[0] = '0;

  for (genvar k = 0; k < NB; k++) begin : g_st
    logic [63:0] rnx, trial;
    logic [31:0] qnx;
    always_comb begin
      trial = {res[k], 2'b01} << (2 * (NB - 1 - k));
      if (rem[k] >= trial) begin
        rnx = rem[k] - trial;
        qnx = {res[k][30:0], 1'b1};
      end else begin
        rnx = rem[k];
        qnx = {res[k][30:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= rnx;
        res[k+1] <= qnx;
      end
    end
  end

  assign root = res[NB][30:0];
endmodule
`default_nettype wire

@@ rtl/core/q2e_checker.sv @@
// Port-level assertions for the quaternion to Euler block and their binding.
`default_nettype none
module q2e_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [14:0] pitch_angle,
  input wire logic pitch_clamped
);
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready)) else $error("ready mismatch");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && pitch_clamped |->
      (pitch_angle == 15'd12868 || pitch_angle == 15'h4DBC))
    else $error("clamped pitch not at half pi");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind quaternion_to_euler q2e_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .pitch_angle(out_ch.pitch_angle),
  .pitch_clamped(out_ch.pitch_clamped)
);
`default_nettype wire

@@ tb/quaternion_to_euler_tb.sv @@
// Self-checking testbench for the quaternion to Euler angle converter.
`timescale 1ns / 1ps
module quaternion_to_euler_tb;

  typedef struct {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  localparam int CordicSteps = 16;
  localparam int QuatFrac = 14;
  localparam int AngFrac = 13;
  localparam int RandomCount = 1600;
  localparam int StallLimit = 4000;
  localparam int DrainCycles = 120;
  localparam longint PiQ30 = 64'sd3373259426;
  localparam longint HalfPiQ30 = 64'sd1686629713;

  logic clk;
  logic rst;

  q2e_in_if in_ch ();
  q2e_out_if out_ch ();

  quaternion_to_euler uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  quat_t pending_quats[$];
  euler_t expected_angles[$];
  int total_items;
  int sent_count;
  int recv_count;
  int clamp_count;
  int error_count;
  int quiet_cycles;
  int send_gap_pct;
  int recv_stall_pct;

  function automatic longint cordic_angle(input int i);
    longint tab[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return tab[i];
    return longint'(1) << (30 - i);
  endfunction

  // Vectoring rotation; returns atan2(ys, xs) with 30 fraction bits.
  function automatic longint arctan2_q30(input longint ys, input longint xs);
    longint xv, yv, zv, m, t, dx, dy;
    xv = xs;
    yv = ys;
    zv = 0;
    if (xv == 0 && yv == 0) return 0;
    m = (xv < 0 ? -xv : xv) > (yv < 0 ? -yv : yv) ? (xv < 0 ? -xv : xv)
                                                    : (yv < 0 ? -yv : yv);
    while (m >= (longint'(1) << 40)) begin
      xv = xv >>> 1;
      yv = yv >>> 1;
      m = m >>> 1;
    end
    while (m < (longint'(1) << 39)) begin
      xv = xv * 2;
      yv = yv * 2;
      m = m * 2;
    end
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv;
        yv = -t;
        zv = HalfPiQ30;
      end else begin
        xv = -yv;
        yv = t;
        zv = -HalfPiQ30;
      end
    end
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv += dx;
        yv -= dy;
        zv += cordic_angle(i);
      end else begin
        xv -= dx;
        yv += dy;
        zv -= cordic_angle(i);
      end
    end
    return zv;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint round_saturate(input longint zq, input longint lim_q30);
    int r;
    longint half, v, lim;
    r = 30 - AngFrac;
    half = longint'(1) << (r - 1);
    v = (zq + half) >>> r;
    lim = (lim_q30 + half) >>> r;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic euler_t euler_of(input quat_t q);
    longint w, x, y, z, one, sr, cr, sp, sy, cy, s30, c30;
    longint unsigned prod;
    euler_t e;
    w = q.w;
    x = q.x;
    y = q.y;
    z = q.z;
    one = longint'(1) << (2 * QuatFrac);
    sr = 2 * (w * x + y * z);
    cr = one - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = one - 2 * (y * y + z * z);
    e.roll = 16'(round_saturate(arctan2_q30(sr, cr), PiQ30));
    e.yaw = 16'(round_saturate(arctan2_q30(sy, cy), PiQ30));
    if (sp >= one || sp <= -one) begin
      e.clamped = 1'b1;
      e.pitch = 15'(round_saturate(sp > 0 ? HalfPiQ30 : -HalfPiQ30, HalfPiQ30));
    end else begin
      e.clamped = 1'b0;
      // Quaternion products carry 28 fraction bits, the sine needs 30.
      s30 = sp * 4;
      prod = longint'((longint'(1) << 30) - s30) * longint'((longint'(1) << 30) + s30);
      c30 = longint'(floor_sqrt(prod));
      e.pitch = 15'(round_saturate(arctan2_q30(s30, c30), HalfPiQ30));
    end
    return e;
  endfunction

  task automatic add_quat(input int w, input int x, input int y, input int z);
    quat_t q;
    q.w = 16'(w);
    q.x = 16'(x);
    q.y = 16'(y);
    q.z = 16'(z);
    pending_quats.push_back(q);
  endtask

  task automatic add_unit_quat();
    real a, b, c, d, n;
    n = 0.0;
    while (n < 0.01) begin
      a = $urandom_range(65535) / 32768.0 - 1.0;
      b = $urandom_range(65535) / 32768.0 - 1.0;
      c = $urandom_range(65535) / 32768.0 - 1.0;
      d = $urandom_range(65535) / 32768.0 - 1.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
    end
    add_quat($rtoi(a / n * 16384.0), $rtoi(b / n * 16384.0),
             $rtoi(c / n * 16384.0), $rtoi(d / n * 16384.0));
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sender side: one item per transfer, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_quats.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        quat_t q;
        q = pending_quats.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.quat_w <= q.w;
        in_ch.quat_x <= q.x;
        in_ch.quat_y <= q.y;
        in_ch.quat_z <= q.z;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        quat_t q;
        q.w = in_ch.quat_w;
        q.x = in_ch.quat_x;
        q.y = in_ch.quat_y;
        q.z = in_ch.quat_z;
        expected_angles.push_back(euler_of(q));
        sent_count++;
      end
      if (out_ch.valid && out_ch.ready) begin
        euler_t e;
        recv_count++;
        if (expected_angles.size() == 0) begin
          $display("%0t: unexpected result roll %0d pitch %0d yaw %0d", $time,
                   out_ch.roll_angle, out_ch.pitch_angle, out_ch.yaw_angle);
          error_count++;
        end else begin
          e = expected_angles.pop_front();
          if (e.clamped) clamp_count++;
          if (out_ch.roll_angle !== e.roll) begin
            $display("%0t: roll expected %0d actual %0d", $time, e.roll, out_ch.roll_angle);
            error_count++;
          end
          if (out_ch.pitch_angle !== e.pitch) begin
            $display("%0t: pitch expected %0d actual %0d", $time, e.pitch,
                     out_ch.pitch_angle);
            error_count++;
          end
          if (out_ch.yaw_angle !== e.yaw) begin
            $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, out_ch.yaw_angle);
            error_count++;
          end
          if (out_ch.pitch_clamped !== e.clamped) begin
            $display("%0t: clamp flag expected %0b actual %0b", $time, e.clamped,
                     out_ch.pitch_clamped);
            error_count++;
          end
        end
      end
      // Idle pattern changes with progress through the stimulus.
      if (sent_count < total_items / 3) begin
        send_gap_pct <= 10;
        recv_stall_pct <= 67;
      end else if (sent_count < 2 * total_items / 3) begin
        send_gap_pct <= 67;
        recv_stall_pct <= 10;
      end else begin
        send_gap_pct <= 0;
        recv_stall_pct <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("quaternion_to_euler verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sel, base;
    in_ch.valid = 1'b0;
    in_ch.quat_w = '0;
    in_ch.quat_x = '0;
    in_ch.quat_y = '0;
    in_ch.quat_z = '0;
    out_ch.ready = 1'b0;
    send_gap_pct = 10;
    recv_stall_pct = 67;
    sent_count = 0;
    recv_count = 0;
    clamp_count = 0;
    error_count = 0;
    quiet_cycles = 0;
    rst = 1'b1;

    // Directed cases: identity, zero vectors, field extremes and pitch edges.
    add_quat(16384, 0, 0, 0);
    add_quat(0, 0, 0, 0);
    add_quat(0, 16384, 0, 0);
    add_quat(0, 0, 0, 16384);
    add_quat(0, 0, 16384, 0);
    add_quat(-16384, -16384, -16384, -16384);
    add_quat(16384, 16384, 16384, 16384);
    add_quat(-32768, -32768, -32768, -32768);
    add_quat(32767, 32767, 32767, 32767);
    add_quat(32767, -32768, 32767, -32768);
    add_quat(16384, 0, 8192, 0);
    add_quat(16384, 0, -8192, 0);
    add_quat(11585, 0, 11585, 0);
    add_quat(11586, 0, 11586, 0);
    add_quat(11585, 0, -11585, 0);
    add_quat(11586, 0, -11586, 0);
    add_quat(0, 8192, 0, -16384);
    add_quat(11585, 11585, 0, 0);
    add_quat(11585, 0, 0, -11585);
    add_quat(1, 0, 0, 0);
    add_quat(-1, 1, -1, 1);
    add_quat(-16384, 0, 0, 0);

    for (int i = 0; i < RandomCount; i++) begin
      sel = $urandom_range(9);
      if (sel < 6) begin
        add_unit_quat();
      end else if (sel < 8) begin
        // Hover near the pitch clamp boundary.
        base = 11585 + $urandom_range(4) - 2;
        add_quat(base, $urandom_range(16) - 8, ($urandom_range(1) ? base : -base),
                 $urandom_range(16) - 8);
      end else begin
        add_quat($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                 $urandom_range(65535));
      end
    end
    total_items = pending_quats.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (sent_count == total_items && expected_angles.size() == 0);
    repeat (DrainCycles) @(posedge clk);

    $display("Checked %0d quaternions (%0d with clamped pitch) over three idle patterns.",
             recv_count, clamp_count);
    if (error_count == 0 && expected_angles.size() == 0) begin
      $display("quaternion_to_euler verification clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("quaternion_to_euler verification failed");
    end
    $finish;
  end

endmodule
